/* rtl/core/piecewise_linear_interpolator_defines.svh */
// Assertion macros shared by the interpolator RTL.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_DEFINES_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define PLI_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define PLI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/core/pli_pkg.sv */
// Package with types and constants of the piecewise linear interpolator.
`timescale 1ns / 1ps
package pli_pkg;
    localparam int MAX_INTERVALS_DEF = 256;
    localparam int POSITION_BITS_DEF = 16;
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int FRAC_BITS         = 16;

    localparam logic [1:0] OP_WR_BP    = 2'd0;
    localparam logic [1:0] OP_WR_SMP   = 2'd1;
    localparam logic [1:0] OP_QUERY    = 2'd2;

    localparam logic [1:0] ST_WRITE  = 2'd0;
    localparam logic [1:0] ST_INTERP = 2'd1;
    localparam logic [1:0] ST_HELD   = 2'd2;
    localparam logic [1:0] ST_OUT    = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_ENDS, S_CHK_ENDS, S_SRCH_RD, S_SRCH_CHK,
        S_RD_INT, S_GET_INT, S_DIV, S_MUL, S_DONE
    } t_state;
endpackage

/* rtl/core/pli_ram.sv */
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module pli_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

/* rtl/core/piecewise_linear_interpolator.sv */
// Top level of the piecewise linear interpolator.
`timescale 1ns / 1ps
// One transaction at a time. A write is accepted, stored if its index is in
// range and answered at once (so is any other non-query opcode): its result is
// presented in the cycle after acceptance, so writes can follow one per cycle
// while the receiver does not stall. A query reads both end breakpoints
// (S_RD_ENDS, S_CHK_ENDS), after which an out of range query presents its
// result. It then binary searches the breakpoint memory, each step reading
// x[mid] in S_SRCH_RD and narrowing the window in S_SRCH_CHK. The interval
// ends and samples are read in S_RD_INT and S_GET_INT, the restoring divider
// forms the fraction in S_DIV, and the multiply and the final sum follow in
// S_MUL and S_DONE. Results sit in an output register, and the next
// transaction is taken in the cycle in which the previous result leaves it.
// Tables hold no reset values.
module piecewise_linear_interpolator #(
    parameter int MAX_INTERVALS = pli_pkg::MAX_INTERVALS_DEF,
    parameter int POSITION_BITS = pli_pkg::POSITION_BITS_DEF,
    parameter int SAMPLE_BITS   = pli_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [$clog2(MAX_INTERVALS + 1)-1:0]  i_cfg_wdata,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [1:0]                            i_opcode,
    input  logic [$clog2(MAX_INTERVALS + 1)-1:0]  i_entry_index,
    input  logic [POSITION_BITS-1:0]              i_breakpoint_value,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample_value,
    input  logic [POSITION_BITS-1:0]              i_query_position,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [SAMPLE_BITS-1:0]         o_result_value,
    output logic [1:0]                            o_status,
    output logic [$clog2(MAX_INTERVALS)-1:0]      o_interval_index
);
    import pli_pkg::*;
    `include "piecewise_linear_interpolator_defines.svh"

    localparam int BA = $clog2(MAX_INTERVALS + 1);
    localparam int SA = $clog2(MAX_INTERVALS);
    localparam int CW = $clog2(MAX_INTERVALS + 1);
    localparam int DW = POSITION_BITS + FRAC_BITS;
    localparam int DCW = $clog2(DW + 1);
    localparam int PW = FRAC_BITS + SAMPLE_BITS + 2;

    t_state r_state, n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] act_n;
    logic [POSITION_BITS-1:0] r_pos, r_x0, r_xl, r_xh;
    logic [BA-1:0] r_lo, r_hi, r_mid, bp_addr;
    logic [BA:0] mid_sum;
    logic [BA-1:0] srch_mid;
    logic [SA-1:0] smp_addr;
    logic bp_we, smp_we;
    logic [POSITION_BITS-1:0] bp_rd;
    logic [SAMPLE_BITS-1:0] smp_rd;
    logic [1:0] r_sub;
    logic signed [SAMPLE_BITS-1:0] r_y0, r_y1;
    logic [DW-1:0] r_num;
    logic [POSITION_BITS:0] r_rem;
    logic [FRAC_BITS-1:0] r_quo;
    logic [DCW-1:0] r_dcnt;
    logic signed [PW-1:0] r_prod;
    logic r_ovalid;
    logic signed [SAMPLE_BITS-1:0] r_res;
    logic [1:0] r_st;
    logic [SA-1:0] r_idx;
    logic [POSITION_BITS:0] rem_sh, rem_sub;
    logic accept;

    // Saturate the interval count into the legal range.
    always_comb begin
        if (r_count < CW'(2)) begin
            act_n = CW'(2);
        end else if (32'(r_count) > MAX_INTERVALS) begin
            act_n = CW'(MAX_INTERVALS);
        end else begin
            act_n = CW'(r_count);
        end
    end

    assign accept = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE) || (r_ovalid && i_stall);

    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign srch_mid = mid_sum[BA:1];

    always_comb begin
        bp_we = accept && i_opcode == OP_WR_BP && 32'(i_entry_index) <= MAX_INTERVALS;
        smp_we = accept && i_opcode == OP_WR_SMP && 32'(i_entry_index) < MAX_INTERVALS;
        bp_addr = r_mid;
        smp_addr = SA'(r_lo);
        if (bp_we) begin
            bp_addr = BA'(i_entry_index);
        end else if (r_state == S_IDLE || r_state == S_RD_ENDS) begin
            bp_addr = (r_state == S_IDLE) ? '0 : BA'(act_n);
        end else if (r_state == S_SRCH_RD) begin
            bp_addr = srch_mid;
        end else if (r_state == S_RD_INT) begin
            bp_addr = (r_sub == 2'd0) ? r_lo : BA'(r_lo + 1'b1);
        end
        if (smp_we) begin
            smp_addr = SA'(i_entry_index);
        end else if (r_state == S_RD_INT && r_sub != 2'd0) begin
            smp_addr = SA'(r_lo + 1'b1);
        end else if (r_state == S_MUL) begin
            // The held sample must be on the read port when the result is formed.
            smp_addr = SA'(act_n - 1'b1);
        end
    end

    pli_ram #(.WIDTH(POSITION_BITS), .DEPTH(MAX_INTERVALS + 1)) u_bp_ram (
        .i_clk(i_clk), .i_we(bp_we), .i_addr(bp_addr),
        .i_wdata(i_breakpoint_value), .o_rdata(bp_rd)
    );
    pli_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_INTERVALS)) u_smp_ram (
        .i_clk(i_clk), .i_we(smp_we), .i_addr(smp_addr),
        .i_wdata(i_sample_value), .o_rdata(smp_rd)
    );

    assign rem_sh  = {r_rem[POSITION_BITS-1:0], r_num[DW-1]};
    assign rem_sub = rem_sh - {1'b0, r_xh - r_xl};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept && i_opcode == OP_QUERY) begin
                n_state = S_RD_ENDS;
            end
            S_RD_ENDS:  n_state = S_CHK_ENDS;
            S_CHK_ENDS: n_state = S_SRCH_RD;
            S_SRCH_RD: begin
                n_state = (r_hi - r_lo > BA'(1)) ? S_SRCH_CHK : S_RD_INT;
            end
            S_SRCH_CHK: n_state = S_SRCH_RD;
            S_RD_INT:   n_state = (r_sub == 2'd2) ? S_GET_INT : S_RD_INT;
            S_GET_INT:  n_state = S_DIV;
            S_DIV:      n_state = (r_dcnt == DCW'(DW)) ? S_MUL : S_DIV;
            S_MUL:      n_state = S_DONE;
            S_DONE:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
        if (r_state == S_CHK_ENDS
            && (r_pos < r_x0 || r_pos > bp_rd)) begin
            n_state = S_IDLE;
        end
        if (r_state == S_CHK_ENDS && n_state != S_IDLE && r_pos >= r_x0
            && 32'(act_n) == 1) begin
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= CW'(2);
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (accept && i_opcode != OP_QUERY) begin
                r_ovalid <= 1'b1;
            end
            if ((r_state == S_CHK_ENDS && (r_pos < r_x0 || r_pos > bp_rd))
                || r_state == S_DONE) begin
                r_ovalid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                // A waiting result stays put until a new transaction is taken.
                if (accept) begin
                    r_pos <= i_query_position;
                    r_res <= '0;
                    r_st  <= ST_WRITE;
                    r_idx <= '0;
                end
            end
            S_RD_ENDS: r_x0 <= bp_rd;
            S_CHK_ENDS: begin
                // Search window: the answer interval lies in [lo, hi).
                r_lo <= '0;
                r_hi <= BA'(act_n - 1'b1);
                r_res <= '0;
                r_st  <= ST_OUT;
                r_idx <= '0;
            end
            S_SRCH_RD: begin
                r_mid <= srch_mid;
                r_sub <= 2'd0;
            end
            S_SRCH_CHK: begin
                // bp_rd is x[mid]; interval is below mid if pos < x[mid].
                if (r_pos < bp_rd) begin
                    r_hi <= r_mid;
                end else begin
                    r_lo <= r_mid;
                end
            end
            S_RD_INT: begin
                r_sub <= r_sub + 2'd1;
                if (r_sub == 2'd1) begin
                    r_xl <= bp_rd;
                    r_y0 <= smp_rd;
                end
            end
            S_GET_INT: begin
                r_xh <= bp_rd;
                r_y1 <= smp_rd;
                r_rem <= '0;
                r_dcnt <= '0;
                r_quo <= '0;
                r_num <= (r_pos > r_xl) ? {r_pos - r_xl, FRAC_BITS'(0)} : '0;
            end
            S_DIV: begin
                // One quotient bit per cycle, restoring division.
                r_dcnt <= r_dcnt + 1'b1;
                if (r_dcnt != DCW'(DW)) begin
                    r_num <= {r_num[DW-2:0], 1'b0};
                    if (!rem_sub[POSITION_BITS] && r_pos > r_xl) begin
                        r_rem <= rem_sub;
                        r_quo <= {r_quo[FRAC_BITS-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[FRAC_BITS-2:0], 1'b0};
                    end
                end
            end
            S_MUL: begin
                r_prod <= $signed({2'b00, r_quo})
                    * (PW'(r_y1) - PW'(r_y0));
            end
            S_DONE: begin
                if (r_pos >= r_xh) begin
                    r_res <= smp_rd;
                    r_st  <= ST_HELD;
                    r_idx <= SA'(act_n - 1'b1);
                end else begin
                    r_res <= SAMPLE_BITS'(r_y0 + SAMPLE_BITS'(r_prod >>> FRAC_BITS));
                    r_st  <= ST_INTERP;
                    r_idx <= SA'(r_lo);
                end
            end
            default: ;
        endcase
        if (r_state == S_IDLE && accept && i_opcode != OP_QUERY) begin
            r_res <= '0;
        end
    end

    // The last window [count-2, count-1) with pos >= x[count-1] holds.
    assign o_valid = r_ovalid;
    assign o_result_value = r_res;
    assign o_status = r_st;
    assign o_interval_index = r_idx;

    `PLI_ASSERT_IMP(a_busy_stalls, r_state != S_IDLE, o_stall)
    `PLI_ASSERT_NEXT(a_query_leaves_idle, accept && i_opcode == OP_QUERY,
        r_state == S_RD_ENDS)
    `PLI_ASSERT_IMP(a_window_ordered, r_state == S_SRCH_CHK, r_lo < r_hi)
    `PLI_ASSERT_IMP(a_no_write_busy, bp_we || smp_we, r_state == S_IDLE)
endmodule

/* tb/pli_checker.sv */
// Checker that predicts and compares every result of the piecewise linear interpolator.
`timescale 1ns / 1ps
module pli_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [8:0]  i_entry_index,
    input  logic [15:0] i_breakpoint_value,
    input  logic [15:0] i_sample_value,
    input  logic [15:0] i_query_position,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [15:0] i_result_value,
    input  logic [1:0]  i_status,
    input  logic [7:0]  i_interval_index,
    output int          o_errors,
    output int          o_pending
);
    import pli_pkg::*;

    typedef struct packed {
        logic [15:0] value;
        logic [1:0]  status;
        logic [7:0]  interval;
    } t_interp_result;

    logic [15:0]    knot_x [0:256];
    logic [15:0]    knot_y [0:255];
    int unsigned    seg_count;
    t_interp_result expected_q [$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
        seg_count = 2;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    function automatic t_interp_result interpolate(input logic [15:0] pos);
        int unsigned    n;
        int unsigned    i;
        longint         xl;
        longint         xh;
        longint         frac;
        longint         y0;
        longint         y1;
        longint         acc;
        bit             hit;
        t_interp_result r;
        r = '0;
        n = (seg_count < 2) ? 2 : ((seg_count > 256) ? 256 : seg_count);
        if (pos < knot_x[0] || pos > knot_x[n]) begin
            r.status = ST_OUT;
        end else begin
            hit = 0;
            for (i = 0; i + 1 < n && !hit; i++) begin
                if (pos < knot_x[i+1]) begin
                    xl   = knot_x[i];
                    xh   = knot_x[i+1];
                    frac = 0;
                    if (pos > xl) begin
                        frac = ((longint'(pos) - xl) << 16) / (xh - xl);
                    end
                    y0  = longint'($signed(knot_y[i]));
                    y1  = longint'($signed(knot_y[i+1]));
                    // Arithmetic shift of the signed product gives the floor.
                    acc = y0 + ((frac * (y1 - y0)) >>> 16);
                    r.value    = acc[15:0];
                    r.status   = ST_INTERP;
                    r.interval = i[7:0];
                    hit = 1;
                end
            end
            if (!hit) begin
                r.value    = knot_y[n-1];
                r.status   = ST_HELD;
                r.interval = 8'(n - 1);
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_interp_result want;
        t_interp_result fresh;
        if (!i_rst_n) begin
            seg_count = 2;
            expected_q.delete();
        end else begin
            // The oldest result leaves before a new transaction is predicted.
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result, status", i_status, -1);
                end else begin
                    want = expected_q.pop_front();
                    if (i_result_value !== want.value)
                        report_mismatch("result_value", $signed(i_result_value),
                                        $signed(want.value));
                    if (i_status !== want.status)
                        report_mismatch("status", i_status, want.status);
                    if (i_interval_index !== want.interval)
                        report_mismatch("interval_index", i_interval_index, want.interval);
                end
            end
            if (i_cfg_we) seg_count = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) begin
                fresh = '0;
                case (i_opcode)
                    OP_WR_BP: begin
                        if (i_entry_index <= 256) knot_x[i_entry_index] = i_breakpoint_value;
                    end
                    OP_WR_SMP: begin
                        if (i_entry_index < 256) knot_y[i_entry_index] = i_sample_value;
                    end
                    OP_QUERY: begin
                        fresh = interpolate(i_query_position);
                    end
                    default: begin
                    end
                endcase
                expected_q.push_back(fresh);
            end
            o_pending = expected_q.size();
        end
    end
endmodule

/* tb/tb_top.sv */
// Testbench top: drives table loads, queries and register writes, and gives the verdict.
`timescale 1ns / 1ps
module tb_top;
    import pli_pkg::*;

    localparam logic [1:0] OP_SPARE = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [8:0]  i_cfg_wdata;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_opcode;
    logic [8:0]  i_entry_index;
    logic [15:0] i_breakpoint_value;
    logic signed [15:0] i_sample_value;
    logic [15:0] i_query_position;
    logic        o_valid;
    logic        i_stall;
    logic signed [15:0] o_result_value;
    logic [1:0]  o_status;
    logic [7:0]  o_interval_index;
    int          errors;
    int          pending;

    // Shadow of the table, used only to keep breakpoints ascending and aim queries.
    logic [15:0] shadow_x [0:256];
    logic [15:0] shadow_y [0:255];
    int unsigned active_n;
    int          burst_left;
    int          hold_requests;
    int          holds_served;
    int          hold_left;
    int          pattern_left;
    int          stall_pct;

    piecewise_linear_interpolator u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_opcode           (i_opcode),
        .i_entry_index      (i_entry_index),
        .i_breakpoint_value (i_breakpoint_value),
        .i_sample_value     (i_sample_value),
        .i_query_position   (i_query_position),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_result_value     (o_result_value),
        .o_status           (o_status),
        .o_interval_index   (o_interval_index)
    );

    pli_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_in_valid         (i_valid),
        .i_in_stall         (o_stall),
        .i_opcode           (i_opcode),
        .i_entry_index      (i_entry_index),
        .i_breakpoint_value (i_breakpoint_value),
        .i_sample_value     (i_sample_value),
        .i_query_position   (i_query_position),
        .i_out_valid        (o_valid),
        .i_out_stall        (i_stall),
        .i_result_value     (o_result_value),
        .i_status           (o_status),
        .i_interval_index   (o_interval_index),
        .o_errors           (errors),
        .o_pending          (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: a changing stall pattern, with a long hold-off on request.
    initial begin
        i_stall      = 1'b0;
        holds_served = 0;
        hold_left    = 0;
        pattern_left = 0;
        stall_pct    = 0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                hold_left    = 400;
            end
            if (pattern_left == 0) begin
                pattern_left = $urandom_range(10, 80);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            pattern_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_stall = 1'b1;
            end else begin
                i_stall = ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Entered and left just after a falling edge.
    task automatic send(input logic [1:0] op, input logic [8:0] idx, input logic [15:0] bpv,
                        input logic [15:0] smp, input logic [15:0] pos);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                i_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid            = 1'b1;
        i_opcode           = op;
        i_entry_index      = idx;
        i_breakpoint_value = bpv;
        i_sample_value     = smp;
        i_query_position   = pos;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic write_knot(input int k, input logic [15:0] v);
        if (k <= 256) shadow_x[k] = v;
        send(OP_WR_BP, 9'(k), v, 16'($urandom), 16'($urandom));
    endtask

    task automatic write_sample(input int k, input logic [15:0] v);
        if (k < 256) shadow_y[k] = v;
        send(OP_WR_SMP, 9'(k), 16'($urandom), v, 16'($urandom));
    endtask

    task automatic query(input logic [15:0] pos);
        send(OP_QUERY, 9'($urandom), 16'($urandom), 16'($urandom), pos);
    endtask

    task automatic drain;
        i_valid    = 1'b0;
        burst_left = 0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_count(input logic [8:0] v);
        drain();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        active_n    = (v < 2) ? 2 : ((v > 256) ? 256 : v);
    endtask

    function automatic logic [15:0] pick_position();
        int k;
        k = $urandom_range(0, active_n);
        case ($urandom_range(0, 9))
            0, 1: return 16'($urandom);
            2, 3, 4, 5: return 16'($urandom_range(shadow_x[0], shadow_x[active_n]));
            6, 7, 8: return shadow_x[k] + 16'($urandom_range(0, 2)) - 16'd1;
            default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    task automatic random_phase(input int items);
        int k;
        int lo;
        int hi;
        int roll;
        repeat (items) begin
            roll = $urandom_range(0, 99);
            if (roll < 80) begin
                query(pick_position());
            end else if (roll < 88) begin
                write_sample($urandom_range(0, 255), 16'($urandom));
            end else if (roll < 96) begin
                // Rewrite a breakpoint between its neighbours so the table stays ascending.
                k  = $urandom_range(0, 256);
                lo = (k == 0) ? 0 : shadow_x[k-1] + 1;
                hi = (k == 256) ? 65535 : shadow_x[k+1] - 1;
                if (lo <= hi) write_knot(k, 16'($urandom_range(lo, hi)));
                else query(pick_position());
            end else if (roll < 98) begin
                send(OP_SPARE, 9'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            end else if (roll < 99) begin
                write_knot($urandom_range(257, 511), 16'($urandom));
            end else begin
                write_sample($urandom_range(256, 511), 16'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = '0;
        i_valid            = 1'b0;
        i_opcode           = OP_WR_BP;
        i_entry_index      = '0;
        i_breakpoint_value = '0;
        i_sample_value     = '0;
        i_query_position   = '0;
        hold_requests      = 0;
        burst_left         = 0;
        active_n           = 2;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Full table spanning the whole position range, samples swinging between extremes.
        for (int k = 0; k <= 256; k++) write_knot(k, (k == 256) ? 16'hFFFF : 16'(k * 256));
        for (int k = 0; k < 256; k++) begin
            case (k % 3)
                0: write_sample(k, 16'h8000);
                1: write_sample(k, 16'h7FFF);
                default: write_sample(k, 16'($urandom));
            endcase
        end

        // Directed queries at the reset count of two intervals.
        query(16'd0);
        query(16'd255);
        query(16'd256);
        query(16'd511);
        query(16'd512);
        query(16'd513);
        query(16'hFFFF);
        send(OP_SPARE, 9'h1FF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        write_knot(257, 16'h1234);
        write_knot(511, 16'hFFFF);
        write_sample(256, 16'h7FFF);
        write_sample(511, 16'h8000);

        set_count(9'd256);
        query(16'hFFFF);
        query(16'hFFFE);
        query(16'hFF00);
        query(16'hFEFF);
        query(16'd0);
        query(16'd1);
        query(16'd128);
        random_phase(90);
        // Long receiver hold-off while items keep coming.
        hold_requests++;
        random_phase(90);
        // Sender pause until every result is back.
        drain();
        random_phase(60);

        set_count(9'd0);
        random_phase(150);
        set_count(9'h1FF);
        random_phase(150);
        set_count(9'($urandom_range(3, 255)));
        random_phase(170);
        set_count(9'd2);
        random_phase(120);
        set_count(9'($urandom_range(200, 256)));
        random_phase(170);

        drain();
        repeat (60) @(negedge i_clk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
